FILE: sv/bam_pkg.sv
`timescale 1ns / 1ps

package bam_pkg;

    localparam int PATTERN_BITS = 32;
    localparam int MAX_LEVELS   = 4;
    localparam int COUNT_BITS   = 24;

    localparam int LETTER_BASE  = 'h61;
    localparam int LETTER_COUNT = 26;

    localparam int CMD_W      = 2;
    localparam int SYMBOL_W   = 8;
    localparam int POSITION_W = 5;
    localparam int HIT_W      = 5;
    localparam int LCOUNT_W   = 24;
    localparam int PLEN_W     = 6;
    localparam int MERR_W     = 3;

    localparam int LEN_W     = $clog2(PATTERN_BITS + 1);
    localparam int ROWIDX_W  = $clog2(PATTERN_BITS);
    localparam int LVL_W     = $clog2(MAX_LEVELS + 1);
    localparam int LETTER_W  = $clog2(LETTER_COUNT);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W    = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1);

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_TEXT  = 2'd2,
        CMD_READ  = 2'd3
    } t_cmd;

    typedef enum logic {
        REG_PATTERN_LENGTH = 1'b0,
        REG_MAX_ERRORS     = 1'b1
    } t_reg;

    typedef logic [PATTERN_BITS-1:0] t_row;
    typedef logic [MAX_LEVELS:0][PATTERN_BITS-1:0] t_rows;
    typedef logic [COUNT_BITS-1:0] t_count;

    typedef struct packed {
        t_cmd                  cmd;
        logic                  letter_ok;
        logic [LETTER_W-1:0]   letter;
        logic [POSITION_W-1:0] position;
    } t_op;

    typedef struct packed {
        logic [HIT_W-1:0]    hit_levels;
        logic                symbol_skipped;
        logic [LCOUNT_W-1:0] level_count;
    } t_result;

endpackage

FILE: sv/bam_if.sv
`timescale 1ns / 1ps

interface bam_in_if;
    logic                           valid;
    logic                           ready;
    logic [bam_pkg::CMD_W-1:0]      cmd;
    logic [bam_pkg::SYMBOL_W-1:0]   symbol;
    logic [bam_pkg::POSITION_W-1:0] position;

    modport source (output valid, output cmd, output symbol, output position, input ready);
    modport sink   (input valid, input cmd, input symbol, input position, output ready);
endinterface

interface bam_out_if;
    logic                         valid;
    logic                         ready;
    logic [bam_pkg::HIT_W-1:0]    hit_levels;
    logic                         symbol_skipped;
    logic [bam_pkg::LCOUNT_W-1:0] level_count;

    modport source (output valid, output hit_levels, output symbol_skipped,
                    output level_count, input ready);
    modport sink   (input valid, input hit_levels, input symbol_skipped,
                    input level_count, output ready);
endinterface

FILE: sv/bam_front.sv
`timescale 1ns / 1ps

module bam_front (
    bam_in_if.sink         i_item,
    output bam_pkg::t_op   o_op,
    output logic           o_op_valid,
    input  logic           i_op_ready
);
    import bam_pkg::*;

    logic [SYMBOL_W-1:0] w_rel;

    // classify the byte as a letter and find its mask slot
    assign w_rel = i_item.symbol - SYMBOL_W'(LETTER_BASE);

    always_comb begin
        o_op.cmd       = t_cmd'(i_item.cmd);
        o_op.letter_ok = (32'(i_item.symbol) >= LETTER_BASE)
                      && (32'(i_item.symbol) < LETTER_BASE + LETTER_COUNT);
        o_op.letter    = w_rel[LETTER_W-1:0];
        o_op.position  = i_item.position;
    end

    assign o_op_valid   = i_item.valid;
    assign i_item.ready = i_op_ready;

endmodule

FILE: sv/bam_queue.sv
`timescale 1ns / 1ps

module bam_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  bam_pkg::t_op  i_op,
    input  logic          i_push_valid,
    output logic          o_push_ready,
    output bam_pkg::t_op  o_op,
    output logic          o_pop_valid,
    input  logic          i_pop_ready
);
    import bam_pkg::*;

    t_op               r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_cnt, n_cnt;
    logic              w_push, w_pop;

    assign o_push_ready = (32'(r_cnt) < QUEUE_DEPTH);
    assign o_pop_valid  = (r_cnt != '0);
    assign o_op         = r_mem[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (w_push) begin
            n_wr_ptr = (32'(r_wr_ptr) == QUEUE_DEPTH - 1) ? '0 : r_wr_ptr + QPTR_W'(1);
        end
        if (w_pop) begin
            n_rd_ptr = (32'(r_rd_ptr) == QUEUE_DEPTH - 1) ? '0 : r_rd_ptr + QPTR_W'(1);
        end
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + QCNT_W'(1);
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

endmodule

FILE: sv/bam_back.sv
`timescale 1ns / 1ps

module bam_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [bam_pkg::LEN_W-1:0]   i_len,
    input  logic [bam_pkg::LVL_W-1:0]   i_levels,
    input  bam_pkg::t_op                i_op,
    input  logic                        i_op_valid,
    output logic                        o_op_ready,
    output bam_pkg::t_result            o_res,
    output logic                        o_res_valid,
    input  logic                        i_res_ready
);
    import bam_pkg::*;

    t_row    r_masks [LETTER_COUNT];
    t_row    n_masks [LETTER_COUNT];
    t_rows   r_rows, n_rows;
    t_count  r_counts [MAX_LEVELS+1];
    t_count  n_counts [MAX_LEVELS+1];
    t_result r_res, n_res;
    logic    r_res_valid, n_res_valid;

    logic                  w_pop;
    t_row                  w_top;
    t_row                  w_mask;
    logic [LEN_W-1:0]      w_bitsel;
    logic [MAX_LEVELS:0]   w_hits;
    logic [63:0]           w_wide;

    function automatic t_rows preset_rows(input t_row top);
        t_rows rows;
        t_row  row;
        row = '0;
        for (int i = 0; i <= MAX_LEVELS; i++) begin
            rows[i] = row;
            row     = (row >> 1) | top;
        end
        return rows;
    endfunction

    assign o_op_ready  = !r_res_valid || i_res_ready;
    assign w_pop       = i_op_valid && o_op_ready;
    assign o_res       = r_res;
    assign o_res_valid = r_res_valid;

    assign w_top    = t_row'(1) << (i_len - LEN_W'(1));
    assign w_mask   = r_masks[i_op.letter];
    assign w_bitsel = i_len - LEN_W'(1) - LEN_W'(i_op.position);

    always_comb begin
        t_row prev_old;
        t_row prev_new;
        t_row nw;
        n_masks     = r_masks;
        n_rows      = r_rows;
        n_counts    = r_counts;
        n_res       = r_res;
        n_res_valid = r_res_valid && !i_res_ready;
        w_hits      = '0;
        w_wide      = '0;
        prev_old    = '0;
        prev_new    = '0;
        nw          = '0;
        if (w_pop) begin
            n_res_valid = 1'b1;
            n_res       = '0;
            unique case (i_op.cmd)
                CMD_CLEAR: begin
                    for (int i = 0; i < LETTER_COUNT; i++) begin
                        n_masks[i] = '0;
                    end
                    for (int i = 0; i <= MAX_LEVELS; i++) begin
                        n_counts[i] = '0;
                    end
                    n_rows = preset_rows(w_top);
                end
                CMD_LOAD: begin
                    if (i_op.letter_ok && (32'(i_op.position) < 32'(i_len))) begin
                        n_masks[i_op.letter] = r_masks[i_op.letter]
                                             | (t_row'(1) << w_bitsel[ROWIDX_W-1:0]);
                    end
                end
                CMD_TEXT: begin
                    if (!i_op.letter_ok) begin
                        n_res.symbol_skipped = 1'b1;
                    end else begin
                        // level chain: exact term, then substitution, insertion, deletion
                        prev_old  = r_rows[0];
                        prev_new  = ((r_rows[0] >> 1) | w_top) & w_mask;
                        n_rows[0] = prev_new;
                        for (int i = 1; i <= MAX_LEVELS; i++) begin
                            if (LVL_W'(i) <= i_levels) begin
                                nw = (((r_rows[i] >> 1) | w_top) & w_mask)
                                   | (((prev_old | prev_new) >> 1) | w_top)
                                   | prev_old;
                                n_rows[i] = nw;
                                prev_old  = r_rows[i];
                                prev_new  = nw;
                            end
                        end
                        for (int i = 0; i <= MAX_LEVELS; i++) begin
                            if ((LVL_W'(i) <= i_levels) && n_rows[i][0]) begin
                                w_hits[i] = 1'b1;
                                if (r_counts[i] != '1) begin
                                    n_counts[i] = r_counts[i] + COUNT_BITS'(1);
                                end
                            end
                        end
                        w_wide           = 64'(w_hits);
                        n_res.hit_levels = w_wide[HIT_W-1:0];
                    end
                end
                CMD_READ: begin
                    if (32'(i_op.position) <= MAX_LEVELS) begin
                        w_wide = 64'(r_counts[i_op.position[LVL_W-1:0]]);
                        n_res.level_count = w_wide[LCOUNT_W-1:0];
                    end
                end
                default: begin
                    n_res = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
            for (int i = 0; i < LETTER_COUNT; i++) begin
                r_masks[i] <= '0;
            end
            for (int i = 0; i <= MAX_LEVELS; i++) begin
                r_counts[i] <= '0;
            end
            r_rows <= preset_rows(t_row'(1));
        end else begin
            r_res_valid <= n_res_valid;
            r_masks     <= n_masks;
            r_counts    <= n_counts;
            r_rows      <= n_rows;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

endmodule

FILE: sv/bitap_approx_matcher.sv
`timescale 1ns / 1ps

// channel   | dir | handshake          | payload
// i_item    | in  | valid / ready      | cmd, symbol, position
// o_result  | out | valid / ready      | hit_levels, symbol_skipped, level_count
// apb       | in  | psel/penable/pready| paddr, pwdata, prdata
//
// one item per cycle sustained while the output is ready; an accepted item passes the queue and the result register
// every error level up to the max-errors setting updates together through the chained row logic of the back end
// reset is synchronous: masks and counters cleared, rows preset for length one
// a two-entry queue sits between decode and execution and keeps taking items
// while a result waits at the output, the input stalls once it holds two

module bitap_approx_matcher (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    bam_in_if.sink                       i_item,
    bam_out_if.source                    o_result,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bam_pkg::APB_AW-1:0]   paddr,
    input  logic [bam_pkg::APB_DW-1:0]   pwdata,
    output logic [bam_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);
    import bam_pkg::*;

    logic [PLEN_W-1:0] r_pattern_length;
    logic [MERR_W-1:0] r_max_errors;
    logic [LEN_W-1:0]  w_len;
    logic [LVL_W-1:0]  w_levels;
    t_reg              w_reg;
    logic              w_wr;

    t_op     w_front_op, w_queue_op;
    logic    w_front_valid, w_front_ready;
    logic    w_queue_valid, w_queue_ready;
    t_result w_res;
    logic    w_res_valid;

    assign pready = 1'b1;
    assign w_reg  = t_reg'(paddr[2]);
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_length <= PLEN_W'(1);
            r_max_errors     <= '0;
        end else if (w_wr) begin
            unique case (w_reg)
                REG_PATTERN_LENGTH: r_pattern_length <= pwdata[PLEN_W-1:0];
                REG_MAX_ERRORS:     r_max_errors     <= pwdata[MERR_W-1:0];
                default:            r_max_errors     <= r_max_errors;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg)
            REG_PATTERN_LENGTH: prdata = APB_DW'(r_pattern_length);
            REG_MAX_ERRORS:     prdata = APB_DW'(r_max_errors);
            default:            prdata = '0;
        endcase
    end

    always_comb begin
        if (r_pattern_length == '0) begin
            w_len = LEN_W'(1);
        end else if (32'(r_pattern_length) > PATTERN_BITS) begin
            w_len = LEN_W'(PATTERN_BITS);
        end else begin
            w_len = LEN_W'(r_pattern_length);
        end
        if (32'(r_max_errors) > MAX_LEVELS) begin
            w_levels = LVL_W'(MAX_LEVELS);
        end else begin
            w_levels = LVL_W'(r_max_errors);
        end
    end

    bam_front u_front (
        .i_item     (i_item),
        .o_op       (w_front_op),
        .o_op_valid (w_front_valid),
        .i_op_ready (w_front_ready)
    );

    bam_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op         (w_front_op),
        .i_push_valid (w_front_valid),
        .o_push_ready (w_front_ready),
        .o_op         (w_queue_op),
        .o_pop_valid  (w_queue_valid),
        .i_pop_ready  (w_queue_ready)
    );

    bam_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_len       (w_len),
        .i_levels    (w_levels),
        .i_op        (w_queue_op),
        .i_op_valid  (w_queue_valid),
        .o_op_ready  (w_queue_ready),
        .o_res       (w_res),
        .o_res_valid (w_res_valid),
        .i_res_ready (o_result.ready)
    );

    assign o_result.valid          = w_res_valid;
    assign o_result.hit_levels     = w_res.hit_levels;
    assign o_result.symbol_skipped = w_res.symbol_skipped;
    assign o_result.level_count    = w_res.level_count;

`ifndef ASSERT_OFF
    a_skip_no_hits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.symbol_skipped) |->
            (o_result.hit_levels == '0 && o_result.level_count == '0))
        else $error("skipped item reports hits or a count");

    a_hits_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> ((32'(o_result.hit_levels) >> (32'(w_levels) + 1)) == 0))
        else $error("hit reported above the evaluated levels");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_result.valid)
        else $error("result valid right after reset");

    a_queue_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_queue_valid && !o_result.valid) |=> o_result.valid)
        else $error("queued item not executed while result register was free");
`endif

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import bam_pkg::*;

    localparam int QUIET_LIMIT  = 4000;
    localparam int ITEM_TARGET  = 1700;
    localparam int PHASE_ITEMS  = 130;

    class bitap_shadow;
        t_row              letter_masks [LETTER_COUNT];
        t_row              level_rows   [MAX_LEVELS+1];
        t_count            hit_counters [MAX_LEVELS+1];
        logic [PLEN_W-1:0] pattern_length;
        logic [MERR_W-1:0] max_errors;
        t_result           expected_q[$];
        int                mismatches;

        function new();
            pattern_length = 1;
            max_errors     = 0;
            mismatches     = 0;
            clear_state();
        endfunction

        function int unsigned active_length();
            int unsigned m;
            m = pattern_length;
            if (m < 1) m = 1;
            if (m > PATTERN_BITS) m = PATTERN_BITS;
            return m;
        endfunction

        function int unsigned active_levels();
            return (max_errors > MAX_LEVELS) ? MAX_LEVELS : max_errors;
        endfunction

        function void clear_state();
            t_row row;
            t_row top;
            row = '0;
            top = t_row'(1) << (active_length() - 1);
            foreach (letter_masks[i]) letter_masks[i] = '0;
            for (int i = 0; i <= MAX_LEVELS; i++) begin
                level_rows[i]   = row;
                hit_counters[i] = '0;
                row = (row >> 1) | top;
            end
        endfunction

        function void take_item(t_cmd cmd, logic [SYMBOL_W-1:0] sym,
                                logic [POSITION_W-1:0] pos);
            t_result     res;
            int unsigned m;
            int unsigned lv;
            t_row        top;
            t_row        mask;
            t_row        prev_old;
            t_row        prev_new;
            t_row        old_row;
            logic        letter;
            res    = '0;
            m      = active_length();
            top    = t_row'(1) << (m - 1);
            letter = (sym >= LETTER_BASE) && (sym < LETTER_BASE + LETTER_COUNT);
            case (cmd)
                CMD_CLEAR: clear_state();
                CMD_LOAD: begin
                    if (letter && pos < m)
                        letter_masks[sym - LETTER_BASE][m - 1 - pos] = 1'b1;
                end
                CMD_TEXT: begin
                    if (!letter) begin
                        res.symbol_skipped = 1'b1;
                    end else begin
                        mask          = letter_masks[sym - LETTER_BASE];
                        lv            = active_levels();
                        prev_old      = level_rows[0];
                        prev_new      = ((level_rows[0] >> 1) | top) & mask;
                        level_rows[0] = prev_new;
                        for (int i = 1; i <= lv; i++) begin
                            old_row = level_rows[i];
                            level_rows[i] = (((old_row >> 1) | top) & mask)
                                          | (((prev_old | prev_new) >> 1) | top)
                                          | prev_old;
                            prev_old = old_row;
                            prev_new = level_rows[i];
                        end
                        for (int i = 0; i <= lv; i++) begin
                            if (level_rows[i][0]) begin
                                res.hit_levels[i] = 1'b1;
                                if (hit_counters[i] != '1) hit_counters[i]++;
                            end
                        end
                    end
                end
                default: begin
                    if (pos <= MAX_LEVELS) res.level_count = hit_counters[pos];
                end
            endcase
            expected_q.insert(expected_q.size(), res);
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: hits %b skipped %b count %0d",
                             got.hit_levels, got.symbol_skipped, got.level_count);
                return;
            end
            want = expected_q.pop_front();
            if (got.hit_levels !== want.hit_levels
                    || got.symbol_skipped !== want.symbol_skipped
                    || got.level_count !== want.level_count) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: expected hits %b skipped %b count %0d, ",
                              "got hits %b skipped %b count %0d"},
                             want.hit_levels, want.symbol_skipped, want.level_count,
                             got.hit_levels, got.symbol_skipped, got.level_count);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    bam_in_if  in_if ();
    bam_out_if out_if ();

    bitap_approx_matcher dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (in_if),
        .o_result (out_if),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    bitap_shadow shadow = new();

    int                    items_sent;
    int                    quiet_cycles;
    int                    stall_left;
    logic                  calm;
    logic [SYMBOL_W-1:0]   pattern_text [PATTERN_BITS];
    int unsigned           alpha_n;

    initial begin
        i_clk = 1'b0;
    end

    always #1 i_clk = ~i_clk;

    // result checking, result side stalls and watchdog bookkeeping
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got.hit_levels     = out_if.hit_levels;
            got.symbol_skipped = out_if.symbol_skipped;
            got.level_count    = out_if.level_count;
            shadow.check_result(got);
        end
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)
                || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (stall_left > 0) begin
            out_if.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else if (!calm && $urandom_range(0, 99) < 8) begin
            out_if.ready <= 1'b0;
            stall_left   <= $urandom_range(0, 3);
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("tb: failure");
        $finish;
    end

    task automatic push_item(t_cmd cmd, int unsigned sym, int unsigned pos);
        logic [SYMBOL_W-1:0]   sym_b;
        logic [POSITION_W-1:0] pos_b;
        sym_b = SYMBOL_W'(sym);
        pos_b = POSITION_W'(pos);
        if (!calm && $urandom_range(0, 99) < 8) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        in_if.valid    <= 1'b1;
        in_if.cmd      <= cmd;
        in_if.symbol   <= sym_b;
        in_if.position <= pos_b;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        shadow.take_item(cmd, sym_b, pos_b);
        items_sent++;
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        while (shadow.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg r, logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (r == REG_PATTERN_LENGTH)
            shadow.pattern_length = value[PLEN_W-1:0];
        else
            shadow.max_errors = value[MERR_W-1:0];
        @(posedge i_clk);
    endtask

    task automatic reconfigure(int unsigned len, int unsigned errs);
        drain();
        write_reg(REG_PATTERN_LENGTH, len);
        write_reg(REG_MAX_ERRORS, errs);
    endtask

    function automatic logic [SYMBOL_W-1:0] alpha_letter();
        return SYMBOL_W'(LETTER_BASE + $urandom_range(0, alpha_n - 1));
    endfunction

    // pattern text with occasional substitutions, deletions and insertions
    task automatic emit_occurrence(int unsigned m);
        int unsigned r;
        for (int p = 0; p < m; p++) begin
            r = $urandom_range(0, 11);
            if (r == 0) begin
                push_item(CMD_TEXT, alpha_letter(), $urandom);
            end else if (r == 2) begin
                push_item(CMD_TEXT, alpha_letter(), $urandom);
                push_item(CMD_TEXT, pattern_text[p], $urandom);
            end else if (r != 1) begin
                push_item(CMD_TEXT, pattern_text[p], $urandom);
            end
        end
    endtask

    initial begin
        int unsigned len;
        int unsigned errs;
        int unsigned m;
        int unsigned r;
        int          phase;
        int          target;

        i_rst_n        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        in_if.valid    = 1'b0;
        in_if.cmd      = CMD_CLEAR;
        in_if.symbol   = '0;
        in_if.position = '0;
        out_if.ready   = 1'b0;
        stall_left     = 0;
        quiet_cycles   = 0;
        items_sent     = 0;
        calm           = 1'b0;
        alpha_n        = LETTER_COUNT;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset state, length one
        push_item(CMD_READ, 0, 0);
        push_item(CMD_TEXT, "a", 0);
        push_item(CMD_LOAD, "a", 0);
        push_item(CMD_TEXT, "a", 0);
        push_item(CMD_LOAD, "b", 1);
        push_item(CMD_LOAD, 8'h7b, 0);
        push_item(CMD_TEXT, 8'h60, 0);
        push_item(CMD_TEXT, 8'hff, 31);
        push_item(CMD_READ, 0, 0);

        // length and errors above range
        reconfigure(63, 7);
        push_item(CMD_CLEAR, 0, 0);
        push_item(CMD_LOAD, "z", 31);
        push_item(CMD_LOAD, "a", 0);
        push_item(CMD_LOAD, "m", 15);
        push_item(CMD_TEXT, "z", 0);
        push_item(CMD_TEXT, "a", 0);
        push_item(CMD_TEXT, 8'h00, 0);
        push_item(CMD_TEXT, "z", 0);
        push_item(CMD_READ, 0, 4);
        push_item(CMD_READ, 0, 5);
        push_item(CMD_READ, 0, 31);

        // zero length clamps to one
        reconfigure(0, 0);
        push_item(CMD_CLEAR, 0, 0);
        push_item(CMD_LOAD, "q", 0);
        push_item(CMD_TEXT, "q", 0);
        push_item(CMD_TEXT, "r", 0);
        push_item(CMD_READ, 0, 0);

        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            case ($urandom_range(0, 9))
                0:       len = 0;
                1:       len = 1;
                2:       len = 32;
                3:       len = 63;
                4:       len = $urandom_range(33, 62);
                5, 6:    len = $urandom_range(1, 32);
                default: len = $urandom_range(2, 8);
            endcase
            case ($urandom_range(0, 4))
                0:       errs = 0;
                1:       errs = 4;
                2:       errs = $urandom_range(5, 7);
                default: errs = $urandom_range(1, 3);
            endcase
            reconfigure(len, errs);
            calm    = (phase == 2);
            alpha_n = $urandom_range(2, LETTER_COUNT);
            m       = shadow.active_length();

            push_item(CMD_CLEAR, $urandom, $urandom);
            for (int p = 0; p < m; p++) begin
                pattern_text[p] = alpha_letter();
                push_item(CMD_LOAD, pattern_text[p], p);
            end

            target = items_sent + PHASE_ITEMS;
            while (items_sent < target) begin
                r = $urandom_range(0, 99);
                if (r < 45)
                    emit_occurrence(m);
                else if (r < 65)
                    push_item(CMD_TEXT, alpha_letter(), $urandom);
                else if (r < 72)
                    push_item(CMD_TEXT, $urandom, $urandom);
                else if (r < 82)
                    push_item(CMD_READ, $urandom,
                              ($urandom_range(0, 9) < 8) ? $urandom_range(0, 7)
                                                         : $urandom_range(0, 31));
                else if (r < 90)
                    push_item(CMD_LOAD, alpha_letter(), $urandom_range(0, 31));
                else if (r < 96)
                    push_item(CMD_LOAD, $urandom, $urandom);
                else if (r < 98)
                    push_item(CMD_CLEAR, $urandom, $urandom);
                else
                    push_item(CMD_TEXT, LETTER_BASE + $urandom_range(0, LETTER_COUNT - 1),
                              $urandom);
            end
            phase++;
        end

        in_if.valid <= 1'b0;
        while (shadow.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (shadow.mismatches == 0 && shadow.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
